// ===== rtl/i2crm_pkg.sv =====
`default_nettype none

package i2crm_pkg;

	localparam int NUM_PAIRS_DEF = 2;
	localparam logic [2:0] ACK_POLLS_RST = 3'd3;

	localparam int S_DATA_W = 40;
	localparam int S_USER_W = 4;
	localparam int M_DATA_W = 16;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_WR   = 3'd1;
	localparam logic [2:0] OP_BWR  = 3'd2;
	localparam logic [2:0] OP_RD   = 3'd3;
	localparam logic [2:0] OP_BRD  = 3'd4;

	typedef enum logic [4:0] {
		PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3, PH_T0, PH_T1, PH_T2, PH_T3,
		PH_A0, PH_A1, PH_A2, PH_A3, PH_AE, PH_R0, PH_R1, PH_R2, PH_R3,
		PH_M0, PH_M1, PH_M2, PH_M3, PH_P0, PH_P1, PH_P2
	} phase_t;

	typedef enum logic [1:0] {
		STG_DEV, STG_REG, STG_WDATA, STG_RADDR
	} stage_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       channel;
		logic [7:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
		logic [7:0] length;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       pin_pair;
		logic       busy_res;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       rx_last;
		logic       data_request;
		logic       nack_seen;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/i2crm_core.sv =====
`default_nettype none

module i2crm_core #(
	parameter int NUM_PAIRS = i2crm_pkg::NUM_PAIRS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire i2crm_pkg::item_t item,
	input  wire logic [2:0]       ack_polls,
	output i2crm_pkg::res_t       res_s2
);

	localparam int CHAIN_MAX = 4;

	typedef struct packed {
		i2crm_pkg::phase_t phase;
		logic              tick;
		logic [3:0]        bit_cnt;
		logic [7:0]        shift;
		logic [7:0]        bytes_left;
		logic [7:0]        dev;
		logic [7:0]        regad;
		logic [7:0]        data;
		logic [2:0]        op;
		logic              pair;
		logic              ack_missing;
		logic              scl;
		logic              sda;
		logic              sda_drv;
		i2crm_pkg::stage_t stage;
		logic [2:0]        polls;
		logic              req_pending;
	} ctx_t;

	typedef struct packed {
		logic       rx_valid;
		logic       rx_last;
		logic [7:0] rx_byte;
		logic       req;
	} ev_t;

	typedef struct packed {
		ctx_t       c;
		ev_t        e;
		logic [1:0] dly;
	} step_t;

	function automatic ctx_t begin_tx(ctx_t c, logic [7:0] b);
		ctx_t o;
		o = c;
		o.shift = b;
		o.bit_cnt = 4'd0;
		o.phase = i2crm_pkg::PH_T0;
		return o;
	endfunction

	function automatic step_t exec_phase(ctx_t c, logic [2:0] polls_cfg, logic sda);
		step_t r;
		r.c = c;
		r.e = '0;
		r.dly = 2'd0;
		unique case (c.phase)
			i2crm_pkg::PH_S0: begin
				r.c.sda_drv = 1'b1; r.c.phase = i2crm_pkg::PH_S1; r.dly = 2'd2;
			end
			i2crm_pkg::PH_S1: begin
				r.c.scl = 1'b1; r.c.sda = 1'b1; r.c.phase = i2crm_pkg::PH_S2; r.dly = 2'd2;
			end
			i2crm_pkg::PH_S2: begin
				r.c.sda = 1'b0; r.c.phase = i2crm_pkg::PH_S3; r.dly = 2'd2;
			end
			i2crm_pkg::PH_S3: begin
				r.c.scl = 1'b0;
				r.c = begin_tx(r.c, (c.stage == i2crm_pkg::STG_RADDR) ?
					(c.dev | 8'h01) : c.dev);
			end
			i2crm_pkg::PH_T0: begin
				r.c.sda_drv = 1'b1; r.c.phase = i2crm_pkg::PH_T1; r.dly = 2'd1;
			end
			i2crm_pkg::PH_T1: begin
				r.c.sda = c.shift[7]; r.c.phase = i2crm_pkg::PH_T2; r.dly = 2'd1;
			end
			i2crm_pkg::PH_T2: begin
				r.c.scl = 1'b1; r.c.phase = i2crm_pkg::PH_T3; r.dly = 2'd2;
			end
			i2crm_pkg::PH_T3: begin
				r.c.shift = {c.shift[6:0], 1'b0};
				r.c.scl = 1'b0;
				r.c.bit_cnt = c.bit_cnt + 4'd1;
				r.c.phase = (r.c.bit_cnt < 4'd8) ? i2crm_pkg::PH_T0 : i2crm_pkg::PH_A0;
			end
			i2crm_pkg::PH_A0: begin
				r.c.sda_drv = 1'b0;
				if (c.op == i2crm_pkg::OP_BWR && c.stage == i2crm_pkg::STG_WDATA &&
						c.bytes_left > 8'd1) begin
					r.c.req_pending = 1'b1;
					r.e.req = 1'b1;
				end
				r.c.phase = i2crm_pkg::PH_A1;
				r.dly = 2'd2;
			end
			i2crm_pkg::PH_A1: begin
				r.c.scl = 1'b1; r.c.polls = 3'd0; r.c.phase = i2crm_pkg::PH_A2;
			end
			i2crm_pkg::PH_A2: begin
				if (c.polls >= polls_cfg) begin
					r.c.ack_missing = 1'b1;
					r.c.phase = i2crm_pkg::PH_AE;
				end else begin
					r.c.phase = i2crm_pkg::PH_A3;
					r.dly = 2'd1;
				end
			end
			i2crm_pkg::PH_A3: begin
				if (!sda) begin
					r.c.phase = i2crm_pkg::PH_AE;
				end else begin
					r.c.polls = c.polls + 3'd1;
					r.c.phase = i2crm_pkg::PH_A2;
					r.dly = 2'd1;
				end
			end
			i2crm_pkg::PH_AE: begin
				r.c.scl = 1'b0;
				unique case (c.stage)
					i2crm_pkg::STG_DEV: begin
						if (c.op == i2crm_pkg::OP_BWR) begin
							if (c.bytes_left != 8'd0) begin
								r.c.stage = i2crm_pkg::STG_WDATA;
								r.c = begin_tx(r.c, c.data);
							end else begin
								r.c.phase = i2crm_pkg::PH_P0;
							end
						end else begin
							r.c.stage = i2crm_pkg::STG_REG;
							r.c = begin_tx(r.c, c.regad);
						end
					end
					i2crm_pkg::STG_REG: begin
						if (c.op == i2crm_pkg::OP_WR) begin
							r.c.stage = i2crm_pkg::STG_WDATA;
							r.c = begin_tx(r.c, c.data);
						end else begin
							r.c.stage = i2crm_pkg::STG_RADDR;
							r.c.phase = i2crm_pkg::PH_S0;
						end
					end
					i2crm_pkg::STG_WDATA: begin
						if (c.bytes_left != 8'd0) begin
							r.c.bytes_left = c.bytes_left - 8'd1;
						end
						if (r.c.bytes_left != 8'd0) begin
							r.c = begin_tx(r.c, c.data);
						end else begin
							r.c.phase = i2crm_pkg::PH_P0;
						end
					end
					default: begin
						if (c.bytes_left != 8'd0) begin
							r.c.bit_cnt = 4'd0;
							r.c.shift = 8'd0;
							r.c.phase = i2crm_pkg::PH_R0;
						end else begin
							r.c.phase = i2crm_pkg::PH_P0;
						end
					end
				endcase
			end
			i2crm_pkg::PH_R0: begin
				r.c.sda_drv = 1'b0; r.c.phase = i2crm_pkg::PH_R1; r.dly = 2'd2;
			end
			i2crm_pkg::PH_R1: begin
				r.c.scl = 1'b1; r.c.phase = i2crm_pkg::PH_R2; r.dly = 2'd1;
			end
			i2crm_pkg::PH_R2: begin
				r.c.shift = {c.shift[6:0], sda};
				r.c.bit_cnt = c.bit_cnt + 4'd1;
				if (r.c.bit_cnt == 4'd8) begin
					r.e.rx_valid = 1'b1;
					r.e.rx_last = (c.bytes_left == 8'd1);
					r.e.rx_byte = r.c.shift;
				end
				r.c.phase = i2crm_pkg::PH_R3;
				r.dly = 2'd1;
			end
			i2crm_pkg::PH_R3: begin
				r.c.scl = 1'b0;
				if (c.bit_cnt < 4'd8) begin
					r.c.phase = i2crm_pkg::PH_R0;
				end else begin
					if (c.bytes_left != 8'd0) begin
						r.c.bytes_left = c.bytes_left - 8'd1;
					end
					r.c.phase = i2crm_pkg::PH_M0;
				end
			end
			i2crm_pkg::PH_M0: begin
				r.c.sda_drv = 1'b1; r.c.phase = i2crm_pkg::PH_M1; r.dly = 2'd1;
			end
			i2crm_pkg::PH_M1: begin
				r.c.sda = (c.bytes_left == 8'd0); r.c.phase = i2crm_pkg::PH_M2; r.dly = 2'd1;
			end
			i2crm_pkg::PH_M2: begin
				r.c.scl = 1'b1; r.c.phase = i2crm_pkg::PH_M3; r.dly = 2'd2;
			end
			i2crm_pkg::PH_M3: begin
				r.c.scl = 1'b0;
				if (c.bytes_left == 8'd0) begin
					r.c.phase = i2crm_pkg::PH_P0;
				end else begin
					r.c.bit_cnt = 4'd0;
					r.c.shift = 8'd0;
					r.c.phase = i2crm_pkg::PH_R0;
				end
			end
			i2crm_pkg::PH_P0: begin
				r.c.sda_drv = 1'b1; r.c.sda = 1'b0; r.c.phase = i2crm_pkg::PH_P1; r.dly = 2'd2;
			end
			i2crm_pkg::PH_P1: begin
				r.c.scl = 1'b1; r.c.phase = i2crm_pkg::PH_P2; r.dly = 2'd1;
			end
			i2crm_pkg::PH_P2: begin
				r.c.sda = 1'b1; r.c.phase = i2crm_pkg::PH_IDLE;
			end
			default: begin
				r.c.phase = i2crm_pkg::PH_IDLE;
			end
		endcase
		return r;
	endfunction

	ctx_t  st_q;
	ctx_t  nxt;
	ev_t   ev;
	step_t r;
	logic  run;
	logic  done;
	logic  is_cmd;

	assign is_cmd = (item.opcode == i2crm_pkg::OP_WR) || (item.opcode == i2crm_pkg::OP_BWR) ||
		(item.opcode == i2crm_pkg::OP_RD) || (item.opcode == i2crm_pkg::OP_BRD);

	// zero-delay phases chain within one tick, at most four deep
	always_comb begin
		nxt = st_q;
		ev = '0;
		r = '0;
		run = 1'b0;
		done = 1'b0;
		if (nxt.req_pending) begin
			nxt.data = item.wr_data;
			nxt.req_pending = 1'b0;
		end
		if (nxt.phase == i2crm_pkg::PH_IDLE) begin
			if (is_cmd) begin
				nxt.op = item.opcode;
				nxt.pair = (NUM_PAIRS > 1) ? item.channel : 1'b0;
				nxt.dev = item.dev_addr;
				nxt.regad = item.reg_addr;
				nxt.data = item.wr_data;
				nxt.bytes_left = (item.opcode == i2crm_pkg::OP_BWR ||
					item.opcode == i2crm_pkg::OP_BRD) ? item.length : 8'd1;
				nxt.ack_missing = 1'b0;
				nxt.stage = i2crm_pkg::STG_DEV;
				nxt.tick = 1'b0;
				nxt.phase = i2crm_pkg::PH_S0;
				run = 1'b1;
			end
		end else if (nxt.tick) begin
			nxt.tick = 1'b0;
		end else begin
			run = 1'b1;
		end
		for (int k = 0; k < CHAIN_MAX; k++) begin
			if (run && !done && nxt.phase != i2crm_pkg::PH_IDLE) begin
				r = exec_phase(nxt, ack_polls, item.sda_in);
				nxt = r.c;
				ev = ev_t'(ev | r.e);
				if (r.dly != 2'd0) begin
					nxt.tick = (r.dly == 2'd2);
					done = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			st_q.phase <= i2crm_pkg::PH_IDLE;
			st_q.stage <= i2crm_pkg::STG_DEV;
			st_q.scl <= 1'b1;
			st_q.sda <= 1'b1;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2.scl_level <= nxt.scl;
			res_s2.sda_level <= nxt.sda;
			res_s2.sda_drive <= nxt.sda_drv;
			res_s2.pin_pair <= nxt.pair;
			res_s2.busy_res <= (nxt.phase != i2crm_pkg::PH_IDLE);
			res_s2.rx_byte <= ev.rx_byte;
			res_s2.rx_valid <= ev.rx_valid;
			res_s2.rx_last <= ev.rx_last;
			res_s2.data_request <= ev.req;
			res_s2.nack_seen <= nxt.ack_missing;
		end
	end

	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == i2crm_pkg::PH_IDLE |-> !st_q.tick)
		else $error("delay pending while idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bit_cnt <= 4'd8)
		else $error("bit counter out of range");

	a_start_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		fire && st_q.phase == i2crm_pkg::PH_IDLE && !is_cmd |=>
		st_q.phase == i2crm_pkg::PH_IDLE)
		else $error("transaction started without a command");

	a_req_bwr: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fire) && $past(nxt.req_pending) && !$past(st_q.req_pending) |->
		st_q.op == i2crm_pkg::OP_BWR && st_q.stage == i2crm_pkg::STG_WDATA)
		else $error("data request outside block write");

endmodule

`default_nettype wire

// ===== rtl/i2c_register_master.sv =====
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tdata, s_tuser (one quarter-bit tick per item)
// m_axis    out  m_tvalid/m_tready  m_tdata, m_tlast (one result per input item)
// cfg       in   cfg_we             cfg_wdata (ack poll count)
//
// one item per cycle sustained while m_tready stays high; after acceptance the item passes
// through the input register, then sequencer step and result register
// m_tready low holds the result register and stalls the input register behind it
// reset releases the bus (scl and sda high, sda not driven), ack polls 3
`default_nettype none

module i2c_register_master #(
	parameter int NUM_PAIRS = i2crm_pkg::NUM_PAIRS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// dev_addr, reg_addr, wr_data, length, sda_in
	input  wire logic [i2crm_pkg::S_DATA_W-1:0]  s_tdata,
	// opcode, channel
	input  wire logic [i2crm_pkg::S_USER_W-1:0]  s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// scl_level, sda_level, sda_drive, pin_pair, busy_res, rx_byte, rx_valid,
	// data_request, nack_seen
	output logic [i2crm_pkg::M_DATA_W-1:0]       m_tdata,
	output logic                                 m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [2:0]                      cfg_wdata
);

	logic             in_valid_s1;
	i2crm_pkg::item_t item_s1;
	i2crm_pkg::item_t item_in;
	logic             out_valid_q;
	logic             advance;
	logic [2:0]       ack_polls_q;
	i2crm_pkg::res_t  res_s2;

	assign advance = !out_valid_q || m_tready;
	assign s_tready = !in_valid_s1 || advance;

	assign item_in.opcode = s_tuser[2:0];
	assign item_in.channel = s_tuser[3];
	assign item_in.dev_addr = s_tdata[7:0];
	assign item_in.reg_addr = s_tdata[15:8];
	assign item_in.wr_data = s_tdata[23:16];
	assign item_in.length = s_tdata[31:24];
	assign item_in.sda_in = s_tdata[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			ack_polls_q <= i2crm_pkg::ACK_POLLS_RST;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= in_valid_s1;
			end
			if (cfg_we) begin
				ack_polls_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	i2crm_core #(
		.NUM_PAIRS(NUM_PAIRS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (in_valid_s1 && advance),
		.item     (item_s1),
		.ack_polls(ack_polls_q),
		.res_s2   (res_s2)
	);

	assign m_tvalid = out_valid_q;
	assign m_tlast = res_s2.rx_last;
	assign m_tdata = {res_s2.nack_seen, res_s2.data_request, res_s2.rx_valid, res_s2.rx_byte,
		res_s2.busy_res, res_s2.pin_pair, res_s2.sda_drive, res_s2.sda_level,
		res_s2.scl_level};

endmodule

`default_nettype wire

// ===== tb/sv/i2c_register_master_test.sv =====
module i2c_register_master_test;
	timeunit 1ns;
	timeprecision 1ps;

	import i2crm_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int PHASE_ITEMS = 310;
	localparam int NUM_PHASES = 6;

	typedef enum int {SDA_LOW, SDA_HIGH, SDA_ANY, SDA_MOSTLY_LOW} sda_mode_e;

	typedef struct {
		item_t     it;
		sda_mode_e mode;
		bit        drain;
		bit        known;
		res_t      want;
	} row_t;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                s_tvalid = 0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	logic                cfg_we = 0;
	logic [2:0]          cfg_wdata = '0;

	i2c_register_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// sequencer state as the block should hold it
	phase_t     bus_ph = PH_IDLE;
	stage_t     stg = STG_DEV;
	logic [2:0] wait_ticks = '0;
	logic [3:0] bits_done = '0;
	logic [7:0] sh = '0;
	logic [7:0] left = '0;
	logic [7:0] dev_q = '0;
	logic [7:0] reg_q = '0;
	logic [7:0] data_q = '0;
	logic [2:0] op_q = '0;
	logic       pair_q = 0;
	logic       nack_q = 0;
	logic       scl_q = 1;
	logic       sda_q = 1;
	logic       drv_q = 0;
	logic       req_pend = 0;
	logic [2:0] polls_cfg = ACK_POLLS_RST;
	int         polls_done = 0;
	logic [7:0] rx_b;
	logic       rx_v, rx_l, req_o;

	res_t pending_bus_q[$];
	row_t rows[$];
	int   bad_fields = 0;
	int   burst_left = 4;
	bit   steady = 0;
	bit   hold_go = 0;
	bit   hold_used = 0;
	int   hold_left = 0;
	int   rx_cyc = 0;

	function automatic void load_byte(logic [7:0] b);
		sh = b;
		bits_done = 0;
		bus_ph = PH_T0;
	endfunction

	function automatic void ack_done();
		case (stg)
			STG_DEV: begin
				if (op_q == OP_BWR) begin
					if (left > 0) begin
						stg = STG_WDATA;
						load_byte(data_q);
					end else begin
						bus_ph = PH_P0;
					end
				end else begin
					stg = STG_REG;
					load_byte(reg_q);
				end
			end
			STG_REG: begin
				if (op_q == OP_WR) begin
					stg = STG_WDATA;
					load_byte(data_q);
				end else begin
					stg = STG_RADDR;
					bus_ph = PH_S0;
				end
			end
			STG_WDATA: begin
				if (left > 0)
					left--;
				if (left > 0)
					load_byte(data_q);
				else
					bus_ph = PH_P0;
			end
			default: begin
				if (left > 0) begin
					bits_done = 0;
					sh = 0;
					bus_ph = PH_R0;
				end else begin
					bus_ph = PH_P0;
				end
			end
		endcase
	endfunction

	// one step of the sequencer, returns the delay in ticks that follows
	function automatic int do_phase(logic sda);
		case (bus_ph)
			PH_S0: begin drv_q = 1; bus_ph = PH_S1; return 2; end
			PH_S1: begin scl_q = 1; sda_q = 1; bus_ph = PH_S2; return 2; end
			PH_S2: begin sda_q = 0; bus_ph = PH_S3; return 2; end
			PH_S3: begin
				scl_q = 0;
				load_byte(stg == STG_RADDR ? (dev_q | 8'h01) : dev_q);
				return 0;
			end
			PH_T0: begin drv_q = 1; bus_ph = PH_T1; return 1; end
			PH_T1: begin sda_q = sh[7]; bus_ph = PH_T2; return 1; end
			PH_T2: begin scl_q = 1; bus_ph = PH_T3; return 2; end
			PH_T3: begin
				sh = sh << 1;
				scl_q = 0;
				bits_done++;
				bus_ph = (bits_done < 8) ? PH_T0 : PH_A0;
				return 0;
			end
			PH_A0: begin
				drv_q = 0;
				if (op_q == OP_BWR && stg == STG_WDATA && left > 1) begin
					req_pend = 1;
					req_o = 1;
				end
				bus_ph = PH_A1;
				return 2;
			end
			PH_A1: begin scl_q = 1; polls_done = 0; bus_ph = PH_A2; return 0; end
			PH_A2: begin
				if (polls_done >= polls_cfg) begin
					nack_q = 1;
					bus_ph = PH_AE;
					return 0;
				end
				bus_ph = PH_A3;
				return 1;
			end
			PH_A3: begin
				if (!sda) begin
					bus_ph = PH_AE;
					return 0;
				end
				polls_done++;
				bus_ph = PH_A2;
				return 1;
			end
			PH_AE: begin scl_q = 0; ack_done(); return 0; end
			PH_R0: begin drv_q = 0; bus_ph = PH_R1; return 2; end
			PH_R1: begin scl_q = 1; bus_ph = PH_R2; return 1; end
			PH_R2: begin
				sh = {sh[6:0], sda};
				bits_done++;
				if (bits_done == 8) begin
					rx_v = 1;
					rx_l = (left == 1);
					rx_b = sh;
				end
				bus_ph = PH_R3;
				return 1;
			end
			PH_R3: begin
				scl_q = 0;
				if (bits_done < 8) begin
					bus_ph = PH_R0;
				end else begin
					if (left > 0)
						left--;
					bus_ph = PH_M0;
				end
				return 0;
			end
			PH_M0: begin drv_q = 1; bus_ph = PH_M1; return 1; end
			PH_M1: begin sda_q = (left == 0); bus_ph = PH_M2; return 1; end
			PH_M2: begin scl_q = 1; bus_ph = PH_M3; return 2; end
			PH_M3: begin
				scl_q = 0;
				if (left == 0) begin
					bus_ph = PH_P0;
				end else begin
					bits_done = 0;
					sh = 0;
					bus_ph = PH_R0;
				end
				return 0;
			end
			PH_P0: begin drv_q = 1; sda_q = 0; bus_ph = PH_P1; return 2; end
			PH_P1: begin scl_q = 1; bus_ph = PH_P2; return 1; end
			PH_P2: begin sda_q = 1; bus_ph = PH_IDLE; return 0; end
			default: begin bus_ph = PH_IDLE; return 0; end
		endcase
	endfunction

	function automatic void run_seq(logic sda);
		int d;
		for (int g = 0; g < 32 && bus_ph != PH_IDLE; g++) begin
			d = do_phase(sda);
			if (d > 0) begin
				wait_ticks = d - 1;
				break;
			end
		end
	endfunction

	function automatic res_t i2c_tick(item_t it);
		res_t r;
		rx_b = 0;
		rx_v = 0;
		rx_l = 0;
		req_o = 0;
		if (req_pend) begin
			data_q = it.wr_data;
			req_pend = 0;
		end
		if (bus_ph == PH_IDLE) begin
			if (it.opcode >= OP_WR && it.opcode <= OP_BRD) begin
				op_q = it.opcode;
				pair_q = it.channel;
				dev_q = it.dev_addr;
				reg_q = it.reg_addr;
				data_q = it.wr_data;
				left = (it.opcode == OP_BWR || it.opcode == OP_BRD) ? it.length : 8'd1;
				nack_q = 0;
				stg = STG_DEV;
				wait_ticks = 0;
				bus_ph = PH_S0;
				run_seq(it.sda_in);
			end
		end else if (wait_ticks > 0) begin
			wait_ticks--;
		end else begin
			run_seq(it.sda_in);
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.sda_drive = drv_q;
		r.pin_pair = pair_q;
		r.busy_res = (bus_ph != PH_IDLE);
		r.rx_byte = rx_b;
		r.rx_valid = rx_v;
		r.rx_last = rx_l;
		r.data_request = req_o;
		r.nack_seen = nack_q;
		return r;
	endfunction

	function automatic logic sda_bit(sda_mode_e m);
		case (m)
			SDA_LOW:        return 1'b0;
			SDA_HIGH:       return 1'b1;
			SDA_MOSTLY_LOW: return ($urandom_range(0, 3) == 0);
			default:        return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic item_t mk(logic [2:0] op, logic ch, logic [7:0] dev, logic [7:0] rg,
			logic [7:0] dat, logic [7:0] len, logic sda);
		item_t it;
		it.opcode = op;
		it.channel = ch;
		it.dev_addr = dev;
		it.reg_addr = rg;
		it.wr_data = dat;
		it.length = len;
		it.sda_in = sda;
		return it;
	endfunction

	function automatic item_t rand_item(logic [2:0] op, sda_mode_e m);
		logic [7:0] len;
		len = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(5, 40)) : 8'($urandom_range(1, 4));
		return mk(op, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
			len, sda_bit(m));
	endfunction

	function automatic void add_row(item_t it, sda_mode_e m, bit drain, bit known, res_t want);
		row_t r;
		r.it = it;
		r.mode = m;
		r.drain = drain;
		r.known = known;
		r.want = want;
		rows.push_back(r);
	endfunction

	task automatic send_tick(item_t it, bit known, res_t want);
		res_t r;
		int gap;
		s_tvalid <= 1;
		s_tdata <= {7'd0, it.sda_in, it.length, it.wr_data, it.reg_addr, it.dev_addr};
		s_tuser <= {it.channel, it.opcode};
		do @(posedge clk); while (!s_tready);
		r = i2c_tick(it);
		pending_bus_q.push_back(known ? want : r);
		if (!steady) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(1, 8);
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 0;
		while (pending_bus_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_polls(logic [2:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		polls_cfg = v;
	endtask

	task automatic cmp_field(string name, int e, int a);
		if (e != a) begin
			bad_fields++;
			$display("%0t %s expected %0h actual %0h", $time, name, e, a);
		end
	endtask

	always @(posedge clk) begin
		res_t got, w;
		if (arst_n && m_tvalid && m_tready) begin
			got.scl_level = m_tdata[0];
			got.sda_level = m_tdata[1];
			got.sda_drive = m_tdata[2];
			got.pin_pair = m_tdata[3];
			got.busy_res = m_tdata[4];
			got.rx_byte = m_tdata[12:5];
			got.rx_valid = m_tdata[13];
			got.data_request = m_tdata[14];
			got.nack_seen = m_tdata[15];
			got.rx_last = m_tlast;
			if (pending_bus_q.size() == 0) begin
				bad_fields++;
				$display("%0t unexpected item expected none actual %0h", $time, m_tdata);
			end else begin
				w = pending_bus_q.pop_front();
				cmp_field("scl_level", w.scl_level, got.scl_level);
				cmp_field("sda_level", w.sda_level, got.sda_level);
				cmp_field("sda_drive", w.sda_drive, got.sda_drive);
				cmp_field("pin_pair", w.pin_pair, got.pin_pair);
				cmp_field("busy_res", w.busy_res, got.busy_res);
				cmp_field("rx_byte", w.rx_byte, got.rx_byte);
				cmp_field("rx_valid", w.rx_valid, got.rx_valid);
				cmp_field("rx_last", w.rx_last, got.rx_last);
				cmp_field("data_request", w.data_request, got.data_request);
				cmp_field("nack_seen", w.nack_seen, got.nack_seen);
			end
		end
		rx_cyc++;
		if (hold_go && !hold_used) begin
			hold_used = 1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else if (rx_cyc[7]) begin
			m_tready <= 1;
		end else begin
			m_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		res_t w;
		res_t none;
		sda_mode_e cur_mode;
		int counted;
		logic [2:0] op;
		logic [2:0] polls;

		none = '0;
		w = '0;
		w.scl_level = 1;
		w.sda_level = 1;
		// bus released after reset
		add_row(mk(OP_TICK, 0, 8'h00, 8'h00, 8'h00, 8'd1, 0), SDA_LOW, 0, 1, w);
		w.sda_drive = 1;
		w.busy_res = 1;
		add_row(mk(OP_WR, 0, 8'h00, 8'h00, 8'h00, 8'd1, 0), SDA_LOW, 1, 1, w);
		add_row(mk(OP_WR, 1, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1), SDA_HIGH, 1, 0, none);
		add_row(mk(OP_RD, 0, 8'hA5, 8'h5A, 8'h00, 8'd1, 0), SDA_ANY, 1, 0, none);
		add_row(mk(OP_RD, 1, 8'hFF, 8'h00, 8'hFF, 8'd1, 1), SDA_HIGH, 1, 0, none);
		add_row(mk(OP_BWR, 0, 8'h3C, 8'h00, 8'h3C, 8'd1, 0), SDA_LOW, 1, 0, none);
		add_row(mk(OP_BWR, 1, 8'h5A, 8'hFF, 8'hC3, 8'd255, 0), SDA_ANY, 1, 0, none);
		add_row(mk(OP_BRD, 0, 8'h80, 8'h01, 8'h00, 8'd1, 1), SDA_HIGH, 1, 0, none);
		add_row(mk(OP_BRD, 1, 8'h01, 8'h80, 8'hFF, 8'd255, 0), SDA_ANY, 1, 0, none);
		add_row(mk(OP_BRD, 0, 8'hFE, 8'h7F, 8'h00, 8'd2, 0), SDA_LOW, 1, 0, none);
		add_row(mk(OP_BWR, 1, 8'h7F, 8'hFE, 8'hA5, 8'd3, 0), SDA_MOSTLY_LOW, 1, 0, none);
		// zero length goes straight to stop after the address
		add_row(mk(OP_BWR, 0, 8'h12, 8'h34, 8'h56, 8'd0, 0), SDA_LOW, 1, 0, none);
		add_row(mk(OP_BRD, 1, 8'h21, 8'h43, 8'h65, 8'd0, 0), SDA_LOW, 1, 0, none);
		// unknown opcode acts as a plain tick
		add_row(mk(OP_UNUSED, 1, 8'hFF, 8'hFF, 8'hFF, 8'd255, 1), SDA_HIGH, 0, 0, none);
		add_row(mk(3'd5, 0, 8'h00, 8'h00, 8'h00, 8'd1, 0), SDA_LOW, 0, 0, none);
		// second command while busy is dropped
		add_row(mk(OP_WR, 1, 8'h44, 8'h55, 8'h66, 8'd1, 0), SDA_LOW, 0, 0, none);
		add_row(mk(OP_RD, 0, 8'h99, 8'h88, 8'h77, 8'd1, 0), SDA_ANY, 1, 0, none);

		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_tick(rows[i].it, rows[i].known, rows[i].want);
			if (rows[i].drain)
				while (bus_ph != PH_IDLE)
					send_tick(rand_item(OP_TICK, rows[i].mode), 0, none);
		end

		counted = 0;
		cur_mode = SDA_MOSTLY_LOW;
		for (int p = 0; p < NUM_PHASES; p++) begin
			while (bus_ph != PH_IDLE)
				send_tick(rand_item(OP_TICK, cur_mode), 0, none);
			drain_results();
			case (p)
				0: polls = 3'd1;
				1: polls = 3'd7;
				2: polls = 3'd0;
				default: polls = 3'($urandom_range(1, 7));
			endcase
			write_polls(polls);
			steady = (p == 3);
			if (p == 4)
				hold_go = 1;
			while (counted < (p + 1) * PHASE_ITEMS) begin
				if (bus_ph == PH_IDLE) begin
					if ($urandom_range(0, 4) == 0) begin
						send_tick(rand_item(OP_TICK, SDA_ANY), 0, none);
					end else begin
						case ($urandom_range(0, 9))
							0, 1:    cur_mode = SDA_HIGH;
							2, 3:    cur_mode = SDA_ANY;
							default: cur_mode = SDA_MOSTLY_LOW;
						endcase
						op = 3'($urandom_range(OP_WR, OP_BRD));
						send_tick(rand_item(op, cur_mode), 0, none);
						counted++;
					end
				end else begin
					op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(OP_WR, OP_BRD)) : OP_TICK;
					send_tick(rand_item(op, cur_mode), 0, none);
					counted++;
				end
			end
		end

		s_tvalid <= 0;
		while (pending_bus_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (bad_fields == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
